@@ hdl/ctfe_pkg.sv @@
// ----------------------------------------------------------------------------
// ctfe_pkg
// Shared types, constants and arithmetic helpers of the crossed-field
// trajectory evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ctfe_pkg;

   // 2 pi with 60 fraction bits, truncated
   localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam int ATAN_COUNT = 30;

   // configuration register indexes
   localparam logic [2:0] REG_FIELD_ENABLE = 3'd0;
   localparam logic [2:0] REG_DRIFT_SPEED  = 3'd1;
   localparam logic [2:0] REG_ANGULAR_FREQ = 3'd2;
   localparam logic [2:0] REG_START_VEL_X  = 3'd3;
   localparam logic [2:0] REG_START_VEL_Y  = 3'd4;
   localparam logic [2:0] REG_START_VEL_Z  = 3'd5;
   localparam logic [2:0] REG_START_POS_Y  = 3'd6;

   // item moving through the phase reduction cells
   typedef struct packed {
      logic        neg;
      logic [31:0] t;
      logic [63:0] mag;
   } red_type;

   // item moving through the rotation cells
   typedef struct packed {
      logic               flip;
      logic [31:0]        t;
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [35:0] a;
   } cordic_type;

   // per-configuration coefficients
   typedef struct packed {
      logic [31:0] d1;
      logic [31:0] d2;
      logic [31:0] a1;
      logic [31:0] a2;
      logic        flag;
   } coef_type;

   function automatic logic [30:0] atan_q30(input int idx);
      logic [30:0] v;
      case (idx)
         0:  v = 31'd843314856;
         1:  v = 31'd497837829;
         2:  v = 31'd263043836;
         3:  v = 31'd133525158;
         4:  v = 31'd67021686;
         5:  v = 31'd33543515;
         6:  v = 31'd16775850;
         7:  v = 31'd8388437;
         8:  v = 31'd4194282;
         9:  v = 31'd2097149;
         10: v = 31'd1048575;
         11: v = 31'd524287;
         12: v = 31'd262143;
         13: v = 31'd131071;
         14: v = 31'd65535;
         15: v = 31'd32767;
         16: v = 31'd16383;
         17: v = 31'd8191;
         18: v = 31'd4095;
         19: v = 31'd2047;
         20: v = 31'd1023;
         21: v = 31'd511;
         22: v = 31'd255;
         23: v = 31'd127;
         24: v = 31'd63;
         25: v = 31'd31;
         26: v = 31'd15;
         27: v = 31'd8;
         28: v = 31'd4;
         29: v = 31'd2;
         default: v = 31'd0;
      endcase
      return v;
   endfunction

   // saturate to 32 bits; bit 32 of the result is the saturation flag
   function automatic logic [32:0] sat32(input logic signed [71:0] v);
      logic [32:0] r;
      if (v > 72'sd2147483647) begin
         r = {1'b1, 32'h7FFFFFFF};
      end else if (v < -72'sd2147483648) begin
         r = {1'b1, 32'h80000000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   // round to nearest, ties up, dropping s fraction bits
   function automatic logic signed [71:0] rnd(input logic signed [71:0] v, input int s);
      logic signed [71:0] half;
      half = 72'sd1 <<< (s - 1);
      return (v + half) >>> s;
   endfunction

endpackage

`default_nettype wire

@@ hdl/ctfe_coef.sv @@
// ----------------------------------------------------------------------------
// ctfe_coef
// Sequential unit that derives D1, D2, A1 and A2 from the configuration
// with a bit-serial restoring divider, restarted by every register write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctfe_coef #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] angular_freq,
   input  wire logic signed [31:0] drift_speed,
   input  wire logic signed [31:0] start_vel_y,
   input  wire logic signed [31:0] start_vel_z,
   output ctfe_pkg::coef_type      coef,
   output logic                    busy
);

   localparam int NUMW = 33 + FRAC_BITS;
   localparam int CW   = $clog2(NUMW);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_LOAD = 6'b000010,
      ST_DIV  = 6'b000100,
      ST_SAT  = 6'b001000,
      ST_MUL  = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   state_type                state_ff, state_in;
   logic [CW-1:0]            cnt_ff;
   logic [31:0]              dmag_ff;
   logic [NUMW-1:0]          q1_ff, q2_ff;
   logic [31:0]              r1_ff, r2_ff;
   logic                     neg1_ff, neg2_ff;
   logic signed [31:0]       d1_ff, d2_ff, a1_ff, a2_ff;
   logic signed [63:0]       p1_ff, p2_ff;
   logic                     flag_ff;

   logic signed [32:0]       n1, n2;
   logic [32:0]              m1, m2;
   logic [32:0]              sh1, sh2;
   logic                     ge1, ge2;
   logic                     big1, big2;
   logic [31:0]              d1_in, d2_in;
   logic [32:0]              s1, s2;

   always_comb begin
      n1  = -33'(start_vel_z);
      n2  = 33'(start_vel_y) - 33'(drift_speed);
      m1  = n1[32] ? 33'(-n1) : 33'(n1);
      m2  = n2[32] ? 33'(-n2) : 33'(n2);
      sh1 = {r1_ff, q1_ff[NUMW-1]};
      sh2 = {r2_ff, q2_ff[NUMW-1]};
      ge1 = sh1 >= {1'b0, dmag_ff};
      ge2 = sh2 >= {1'b0, dmag_ff};
      big1 = neg1_ff ? (q1_ff > NUMW'(64'h80000000)) : (q1_ff > NUMW'(64'h7FFFFFFF));
      big2 = neg2_ff ? (q2_ff > NUMW'(64'h80000000)) : (q2_ff > NUMW'(64'h7FFFFFFF));
      d1_in = big1 ? (neg1_ff ? 32'h80000000 : 32'h7FFFFFFF)
                   : (neg1_ff ? -q1_ff[31:0] : q1_ff[31:0]);
      d2_in = big2 ? (neg2_ff ? 32'h80000000 : 32'h7FFFFFFF)
                   : (neg2_ff ? -q2_ff[31:0] : q2_ff[31:0]);
      s1 = ctfe_pkg::sat32(72'(p1_ff >>> FRAC_BITS));
      s2 = ctfe_pkg::sat32(72'(p2_ff >>> FRAC_BITS));
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: state_in = ST_IDLE;
         ST_LOAD: state_in = ST_DIV;
         ST_DIV:  state_in = (cnt_ff == CW'(NUMW - 1)) ? ST_SAT : ST_DIV;
         ST_SAT:  state_in = ST_MUL;
         ST_MUL:  state_in = ST_FIN;
         ST_FIN:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (start) begin
         state_in = ST_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_LOAD: begin
            q1_ff   <= NUMW'(m1) << FRAC_BITS;
            q2_ff   <= NUMW'(m2) << FRAC_BITS;
            dmag_ff <= angular_freq[31] ? 32'(-angular_freq) : 32'(angular_freq);
            neg1_ff <= n1[32] ^ angular_freq[31];
            neg2_ff <= n2[32] ^ angular_freq[31];
            r1_ff   <= '0;
            r2_ff   <= '0;
            cnt_ff  <= '0;
         end
         ST_DIV: begin
            r1_ff  <= ge1 ? 32'(sh1 - {1'b0, dmag_ff}) : sh1[31:0];
            r2_ff  <= ge2 ? 32'(sh2 - {1'b0, dmag_ff}) : sh2[31:0];
            q1_ff  <= {q1_ff[NUMW-2:0], ge1};
            q2_ff  <= {q2_ff[NUMW-2:0], ge2};
            cnt_ff <= cnt_ff + CW'(1);
         end
         ST_SAT: begin
            d1_ff   <= $signed(d1_in);
            d2_ff   <= $signed(d2_in);
            flag_ff <= big1 | big2;
         end
         ST_MUL: begin
            p1_ff <= 64'(d1_ff) * 64'(angular_freq);
            p2_ff <= 64'(d2_ff) * 64'(angular_freq);
         end
         ST_FIN: begin
            a1_ff   <= $signed(s1[31:0]);
            a2_ff   <= $signed(s2[31:0]);
            flag_ff <= flag_ff | s1[32] | s2[32];
         end
         default: begin
         end
      endcase
   end

   assign coef = '{d1: d1_ff, d2: d2_ff, a1: a1_ff, a2: a2_ff, flag: flag_ff};
   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

@@ hdl/ctfe_red_cell.sv @@
// ----------------------------------------------------------------------------
// ctfe_red_cell
// One phase reduction cell: subtract 2 pi times a fixed power of two when
// the magnitude reaches it, and hand the item to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctfe_red_cell #(
   parameter int FRAC_BITS = 16,
   parameter int SHIFT     = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              valid_in,
   input  ctfe_pkg::red_type      data_in,
   output logic                   valid_out,
   output ctfe_pkg::red_type      data_out
);

   localparam logic [63:0] TP   = ctfe_pkg::TWO_PI_Q60 >> (60 - 2 * FRAC_BITS);
   localparam logic [63:0] STEP = TP << SHIFT;

   logic              valid_ff;
   ctfe_pkg::red_type data_ff, data_in_red;

   always_comb begin
      data_in_red = data_in;
      if (data_in.mag >= STEP) begin
         data_in_red.mag = data_in.mag - STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in_red;
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

`default_nettype wire

@@ hdl/ctfe_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// ctfe_cordic_cell
// One rotation-mode CORDIC micro-rotation with its own arctangent constant.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctfe_cordic_cell #(
   parameter int IDX = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              valid_in,
   input  ctfe_pkg::cordic_type   data_in,
   output logic                   valid_out,
   output ctfe_pkg::cordic_type   data_out
);

   localparam logic signed [35:0] ATAN = $signed(36'(ctfe_pkg::atan_q30(IDX)));

   logic                 valid_ff;
   ctfe_pkg::cordic_type data_ff, data_in_rot;

   always_comb begin
      data_in_rot = data_in;
      if (data_in.a >= 36'sd0) begin
         data_in_rot.x = data_in.x - (data_in.y >>> IDX);
         data_in_rot.y = data_in.y + (data_in.x >>> IDX);
         data_in_rot.a = data_in.a - ATAN;
      end else begin
         data_in_rot.x = data_in.x + (data_in.y >>> IDX);
         data_in_rot.y = data_in.y - (data_in.x >>> IDX);
         data_in_rot.a = data_in.a + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in_rot;
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

`default_nettype wire

@@ hdl/crossed_field_trajectory_eval_top.sv @@
// ----------------------------------------------------------------------------
// crossed_field_trajectory_eval_top
// Closed-form position and velocity of a charged particle in uniform crossed
// E and B fields, evaluated at one time point per transaction.
//
//  channel   ports                      handshake
//  -------   -------------------------  ---------------------------------
//  request   start, busy, req_*         taken when start high, busy low
//  response  rsp_strobe, rsp_*          one cycle per result, no back-pressure
//  config    psel..prdata, pready       APB write on psel&penable&pwrite
//
//  One transaction enters per cycle while busy is low. Each passes through
//  the phase product, the magnitude register, the phase reduction cells,
//  the fold register, the CORDIC cells and the product and output registers.
//  Every register write reloads the coefficient divider: busy stays high
//  until the divider run started by the last write has finished.
//  Reset clears the configuration and drops all transactions in flight.
//  The receiver cannot stall; results leave on fixed cycles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crossed_field_trajectory_eval_top #(
   parameter int FRAC_BITS     = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_time_point,
   // response
   output logic             rsp_strobe,
   output logic [31:0]      rsp_pos_x,
   output logic [31:0]      rsp_pos_y,
   output logic [31:0]      rsp_pos_z,
   output logic [31:0]      rsp_vel_x,
   output logic [31:0]      rsp_vel_y,
   output logic [31:0]      rsp_vel_z,
   output logic             rsp_overflow_flag,
   // configuration
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   // number of reduction cells: one per quotient bit of |w*t| / 2 pi
   localparam int NRED = 62 - 2 * FRAC_BITS;
   localparam int NCOR = CORDIC_STAGES;
   localparam int LAT  = NRED + NCOR + 5;
   localparam int SHR  = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
   localparam int SHL  = (2 * FRAC_BITS < 30) ? 30 - 2 * FRAC_BITS : 0;
   localparam logic [63:0] TP = ctfe_pkg::TWO_PI_Q60 >> (60 - 2 * FRAC_BITS);
   localparam logic signed [35:0] PI30   = $signed(36'(ctfe_pkg::TWO_PI_Q60 >> 31));
   localparam logic signed [35:0] HALF30 = $signed(36'(ctfe_pkg::TWO_PI_Q60 >> 32));
   localparam logic signed [35:0] TWO30  = $signed(36'(ctfe_pkg::TWO_PI_Q60 >> 30));

   // ---------------------------------------------------------------- config
   logic               en_ff;
   logic signed [31:0] drift_ff, freq_ff, vx0_ff, vy0_ff, vz0_ff, y0_ff;
   logic               cfg_wr;
   logic [2:0]         cfg_idx;

   assign cfg_wr  = psel & penable & pwrite;
   assign cfg_idx = paddr[4:2];
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff    <= 1'b0;
         drift_ff <= '0;
         freq_ff  <= '0;
         vx0_ff   <= '0;
         vy0_ff   <= '0;
         vz0_ff   <= '0;
         y0_ff    <= '0;
      end else if (cfg_wr) begin
         case (cfg_idx)
            ctfe_pkg::REG_FIELD_ENABLE: en_ff    <= pwdata[0];
            ctfe_pkg::REG_DRIFT_SPEED:  drift_ff <= $signed(pwdata);
            ctfe_pkg::REG_ANGULAR_FREQ: freq_ff  <= $signed(pwdata);
            ctfe_pkg::REG_START_VEL_X:  vx0_ff   <= $signed(pwdata);
            ctfe_pkg::REG_START_VEL_Y:  vy0_ff   <= $signed(pwdata);
            ctfe_pkg::REG_START_VEL_Z:  vz0_ff   <= $signed(pwdata);
            ctfe_pkg::REG_START_POS_Y:  y0_ff    <= $signed(pwdata);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         ctfe_pkg::REG_FIELD_ENABLE: prdata = {31'd0, en_ff};
         ctfe_pkg::REG_DRIFT_SPEED:  prdata = drift_ff;
         ctfe_pkg::REG_ANGULAR_FREQ: prdata = freq_ff;
         ctfe_pkg::REG_START_VEL_X:  prdata = vx0_ff;
         ctfe_pkg::REG_START_VEL_Y:  prdata = vy0_ff;
         ctfe_pkg::REG_START_VEL_Z:  prdata = vz0_ff;
         ctfe_pkg::REG_START_POS_Y:  prdata = y0_ff;
         default:                    prdata = 32'd0;
      endcase
   end

   // recompute D1, D2, A1, A2 after every write; hold off requests meanwhile
   ctfe_pkg::coef_type coef;
   logic               coef_busy;

   ctfe_coef #(.FRAC_BITS(FRAC_BITS)) u_coef (
      .clock        (clock),
      .reset        (reset),
      .start        (cfg_wr),
      .angular_freq (freq_ff),
      .drift_speed  (drift_ff),
      .start_vel_y  (vy0_ff),
      .start_vel_z  (vz0_ff),
      .coef         (coef),
      .busy         (coef_busy)
   );

   assign busy = coef_busy;

   logic acc;
   assign acc = start & ~busy;

   // ----------------------------------------------------- phase product w*t
   logic               s0_valid_ff;
   logic [31:0]        s0_t_ff;
   logic signed [63:0] s0_ph_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= acc;
      end
   end

   always_ff @(posedge clock) begin
      s0_t_ff  <= req_time_point;
      s0_ph_ff <= 64'(freq_ff) * 64'($signed({1'b0, req_time_point}));
   end

   // ------------------------------------------------ magnitude, then cells
   logic              red_valid [0:NRED];
   ctfe_pkg::red_type red_data  [0:NRED];

   always_ff @(posedge clock) begin
      if (reset) begin
         red_valid[0] <= 1'b0;
      end else begin
         red_valid[0] <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      red_data[0].neg <= s0_ph_ff[63];
      red_data[0].t   <= s0_t_ff;
      red_data[0].mag <= s0_ph_ff[63] ? 64'(-s0_ph_ff) : 64'(s0_ph_ff);
   end

   // peel one quotient bit per cell, largest multiple of 2 pi first
   for (genvar j = 0; j < NRED; j++) begin : g_red
      ctfe_red_cell #(
         .FRAC_BITS (FRAC_BITS),
         .SHIFT     (NRED - 1 - j)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (red_valid[j]),
         .data_in   (red_data[j]),
         .valid_out (red_valid[j+1]),
         .data_out  (red_data[j+1])
      );
   end

   // ------------------------------------- wrap into [0, 2 pi), fold to Q30
   logic [63:0]          rem, r_pos, a64;
   logic signed [35:0]   a_wrap;
   ctfe_pkg::cordic_type fold;
   logic                 cor_valid [0:NCOR];
   ctfe_pkg::cordic_type cor_data  [0:NCOR];

   always_comb begin
      rem    = red_data[NRED].mag;
      r_pos  = (red_data[NRED].neg && (rem != 64'd0)) ? TP - rem : rem;
      a64    = (r_pos >> SHR) << SHL;
      a_wrap = $signed(a64[35:0]);
      if (a_wrap > PI30) begin
         a_wrap = a_wrap - TWO30;
      end
      fold.t    = red_data[NRED].t;
      fold.x    = ctfe_pkg::CORDIC_GAIN_Q30;
      fold.y    = '0;
      fold.flip = 1'b0;
      fold.a    = a_wrap;
      if (a_wrap > HALF30) begin
         fold.a    = a_wrap - PI30;
         fold.flip = 1'b1;
      end else if (a_wrap < -HALF30) begin
         fold.a    = a_wrap + PI30;
         fold.flip = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cor_valid[0] <= 1'b0;
      end else begin
         cor_valid[0] <= red_valid[NRED];
      end
   end

   always_ff @(posedge clock) begin
      cor_data[0] <= fold;
   end

   for (genvar i = 0; i < NCOR; i++) begin : g_cor
      ctfe_cordic_cell #(.IDX(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (cor_valid[i]),
         .data_in   (cor_data[i]),
         .valid_out (cor_valid[i+1]),
         .data_out  (cor_data[i+1])
      );
   end

   // ------------------------------------------------------- product stage
   logic signed [33:0] sn, cs;
   logic signed [31:0] d1, d2, a1, a2;
   logic signed [32:0] t_s;
   logic               m_valid_ff;
   logic signed [65:0] m_a1s_ff, m_a2c_ff, m_a2s_ff, m_a1c_ff;
   logic signed [65:0] m_d1c_ff, m_d2s_ff, m_d2c_ff, m_d1s_ff;
   logic signed [64:0] m_vt_ff, m_vxt_ff, m_vyt_ff, m_vzt_ff;

   assign sn  = cor_data[NCOR].flip ? -cor_data[NCOR].y : cor_data[NCOR].y;
   assign cs  = cor_data[NCOR].flip ? -cor_data[NCOR].x : cor_data[NCOR].x;
   assign d1  = $signed(coef.d1);
   assign d2  = $signed(coef.d2);
   assign a1  = $signed(coef.a1);
   assign a2  = $signed(coef.a2);
   assign t_s = $signed({1'b0, cor_data[NCOR].t});

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= cor_valid[NCOR];
      end
   end

   always_ff @(posedge clock) begin
      m_a1s_ff <= 66'(a1) * 66'(sn);
      m_a2c_ff <= 66'(a2) * 66'(cs);
      m_a2s_ff <= 66'(a2) * 66'(sn);
      m_a1c_ff <= 66'(a1) * 66'(cs);
      m_d1c_ff <= 66'(d1) * 66'(cs);
      m_d2s_ff <= 66'(d2) * 66'(sn);
      m_d2c_ff <= 66'(d2) * 66'(cs);
      m_d1s_ff <= 66'(d1) * 66'(sn);
      m_vt_ff  <= 65'(drift_ff) * 65'(t_s);
      m_vxt_ff <= 65'(vx0_ff) * 65'(t_s);
      m_vyt_ff <= 65'(vy0_ff) * 65'(t_s);
      m_vzt_ff <= 65'(vz0_ff) * 65'(t_s);
   end

   // ------------------------------------ sums, rounding, saturation, select
   logic        field_on;
   logic [32:0] px_s, vy_s, vz_s, py_s, pz_s, pyd_s, pzd_s;
   logic        out_valid_ff;
   logic [31:0] out_px_ff, out_py_ff, out_pz_ff, out_vx_ff, out_vy_ff, out_vz_ff;
   logic        out_flag_ff;
   logic [31:0] px_in, py_in, pz_in, vy_in, vz_in;
   logic        flag_in;

   assign field_on = en_ff & (freq_ff != 32'sd0);

   always_comb begin
      px_s  = ctfe_pkg::sat32(ctfe_pkg::rnd(72'(m_vxt_ff), FRAC_BITS));
      vy_s  = ctfe_pkg::sat32(ctfe_pkg::rnd((72'(drift_ff) <<< 30) - 72'(m_a1s_ff)
                                            + 72'(m_a2c_ff), 30));
      vz_s  = ctfe_pkg::sat32(ctfe_pkg::rnd(-72'(m_a2s_ff) - 72'(m_a1c_ff), 30));
      py_s  = ctfe_pkg::sat32(ctfe_pkg::rnd(72'(m_vt_ff), FRAC_BITS)
                              + ctfe_pkg::rnd(72'(m_d1c_ff) + 72'(m_d2s_ff), 30)
                              + 72'(y0_ff) - 72'(d1));
      pz_s  = ctfe_pkg::sat32(ctfe_pkg::rnd(72'(m_d2c_ff) - 72'(m_d1s_ff), 30)
                              - 72'(d2));
      pyd_s = ctfe_pkg::sat32(ctfe_pkg::rnd(72'(m_vyt_ff), FRAC_BITS));
      pzd_s = ctfe_pkg::sat32(ctfe_pkg::rnd(72'(m_vzt_ff), FRAC_BITS));
      px_in = px_s[31:0];
      if (field_on) begin
         py_in   = py_s[31:0];
         pz_in   = pz_s[31:0];
         vy_in   = vy_s[31:0];
         vz_in   = vz_s[31:0];
         flag_in = px_s[32] | coef.flag | vy_s[32] | vz_s[32] | py_s[32] | pz_s[32];
      end else begin
         // straight line; an enabled field with zero frequency still flags
         py_in   = pyd_s[31:0];
         pz_in   = pzd_s[31:0];
         vy_in   = vy0_ff;
         vz_in   = vz0_ff;
         flag_in = px_s[32] | en_ff | pyd_s[32] | pzd_s[32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_px_ff   <= px_in;
      out_py_ff   <= py_in;
      out_pz_ff   <= pz_in;
      out_vx_ff   <= vx0_ff;
      out_vy_ff   <= vy_in;
      out_vz_ff   <= vz_in;
      out_flag_ff <= flag_in;
   end

   assign rsp_strobe        = out_valid_ff;
   assign rsp_pos_x         = out_px_ff;
   assign rsp_pos_y         = out_py_ff;
   assign rsp_pos_z         = out_pz_ff;
   assign rsp_vel_x         = out_vx_ff;
   assign rsp_vel_y         = out_vy_ff;
   assign rsp_vel_z         = out_vz_ff;
   assign rsp_overflow_flag = out_flag_ff;

`ifndef SYNTHESIS
   // a result leaves only where a request was taken earlier
   a_fixed_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(acc, LAT))
      else $error("result without matching request");

   // a register write always restarts the coefficient unit
   a_write_reloads : assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> busy)
      else $error("write did not reload coefficients");

   // no request is taken while coefficients are being rebuilt
   a_no_accept_busy : assert property (@(posedge clock) disable iff (reset)
      $past(cfg_wr) |-> !acc)
      else $error("request taken during coefficient reload");
`endif

endmodule

`default_nettype wire

@@ tb/sv/crossed_field_trajectory_eval_top_tb.sv @@
// ----------------------------------------------------------------------------
// crossed_field_trajectory_eval_top_tb
// Self-checking bench for the crossed-field trajectory evaluator: walks the
// block through straight-line, zero-frequency and crossed-field settings,
// predicts every result in fixed point and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crossed_field_trajectory_eval_top_tb;

   typedef logic signed [71:0] wide_type;

   typedef struct {
      logic [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
      logic        ovf;
   } motion_type;

   // Scoreboard: owns a copy of the configuration and the queue of
   // trajectory points still due from the pipeline.
   class trajectory_board;
      bit          field_on;
      wide_type    drift, omega, v0x, v0y, v0z, y0;
      motion_type  due_q[$];
      int          errors;
      int          checked;

      function wide_type rnd_q(wide_type v, int s);
         return (v + (wide_type'(1) <<< (s - 1))) >>> s;
      endfunction

      function wide_type clamp(wide_type v, inout bit f);
         if (v > 72'sd2147483647) begin
            f = 1;
            return 72'sd2147483647;
         end
         if (v < -72'sd2147483648) begin
            f = 1;
            return -72'sd2147483648;
         end
         return v;
      endfunction

      function void rotate(wide_type phase, output wide_type sn, output wide_type cs);
         wide_type arc[16];
         wide_type tp, pi30, half30, two30, r, a, x, y, nx;
         bit       flip;
         arc = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                 131071, 65535, 32767};
         tp     = wide_type'(ctfe_pkg::TWO_PI_Q60 >> 28);
         pi30   = wide_type'(ctfe_pkg::TWO_PI_Q60 >> 31);
         half30 = wide_type'(ctfe_pkg::TWO_PI_Q60 >> 32);
         two30  = wide_type'(ctfe_pkg::TWO_PI_Q60 >> 30);
         flip   = 0;
         // reduce into [0, 2 pi), then fold into [-pi/2, pi/2]
         r = phase % tp;
         if (r < 0) r += tp;
         a = r >>> 2;
         if (a > pi30) a -= two30;
         if (a > half30) begin
            a -= pi30;
            flip = 1;
         end else if (a < -half30) begin
            a += pi30;
            flip = 1;
         end
         x = wide_type'(ctfe_pkg::CORDIC_GAIN_Q30);
         y = 0;
         for (int i = 0; i < 16; i++) begin
            if (a >= 0) begin
               nx = x - (y >>> i);
               y  = y + (x >>> i);
               a  = a - arc[i];
            end else begin
               nx = x + (y >>> i);
               y  = y - (x >>> i);
               a  = a + arc[i];
            end
            x = nx;
         end
         sn = flip ? -y : y;
         cs = flip ? -x : x;
      endfunction

      // note an accepted transaction: predict its trajectory point
      function void note_time(logic [31:0] tp_in);
         motion_type m;
         wide_type   t, px, py, pz, vy, vz, d1, d2, a1, a2, sn, cs;
         bit         f;
         f  = 0;
         t  = wide_type'({1'b0, tp_in});
         px = clamp(rnd_q(v0x * t, 16), f);
         if (field_on && omega != 0) begin
            d1 = clamp((-v0z * 65536) / omega, f);
            d2 = clamp(((v0y - drift) * 65536) / omega, f);
            a1 = clamp((d1 * omega) >>> 16, f);
            a2 = clamp((d2 * omega) >>> 16, f);
            rotate(omega * t, sn, cs);
            vy = clamp(rnd_q((drift <<< 30) - a1 * sn + a2 * cs, 30), f);
            vz = clamp(rnd_q(-a2 * sn - a1 * cs, 30), f);
            py = clamp(rnd_q(drift * t, 16) + rnd_q(d1 * cs + d2 * sn, 30) + y0 - d1, f);
            pz = clamp(rnd_q(d2 * cs - d1 * sn, 30) - d2, f);
         end else begin
            if (field_on) f = 1;
            vy = v0y;
            vz = v0z;
            py = clamp(rnd_q(v0y * t, 16), f);
            pz = clamp(rnd_q(v0z * t, 16), f);
         end
         m.pos_x = px[31:0];
         m.pos_y = py[31:0];
         m.pos_z = pz[31:0];
         m.vel_x = v0x[31:0];
         m.vel_y = vy[31:0];
         m.vel_z = vz[31:0];
         m.ovf   = f;
         due_q.push_back(m);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, checked);
         errors++;
      endtask

      task check_point(motion_type got);
         motion_type want;
         if (due_q.size() == 0) begin
            report("unexpected result", 32'h0, 32'h0);
            return;
         end
         want = due_q.pop_front();
         if (got.pos_x !== want.pos_x) report("pos_x", got.pos_x, want.pos_x);
         if (got.pos_y !== want.pos_y) report("pos_y", got.pos_y, want.pos_y);
         if (got.pos_z !== want.pos_z) report("pos_z", got.pos_z, want.pos_z);
         if (got.vel_x !== want.vel_x) report("vel_x", got.vel_x, want.vel_x);
         if (got.vel_y !== want.vel_y) report("vel_y", got.vel_y, want.vel_y);
         if (got.vel_z !== want.vel_z) report("vel_z", got.vel_z, want.vel_z);
         if (got.ovf !== want.ovf) report("overflow_flag", 32'(got.ovf), 32'(want.ovf));
         checked++;
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_time_point;
   logic        rsp_strobe;
   logic [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_vel_x, rsp_vel_y, rsp_vel_z;
   logic        rsp_overflow_flag;
   logic        psel, penable, pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   trajectory_board board;
   int          idle_pct;
   int          sent;
   int          settings_run;

   crossed_field_trajectory_eval_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_time_point    (req_time_point),
      .rsp_strobe        (rsp_strobe),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_pos_z         (rsp_pos_z),
      .rsp_vel_x         (rsp_vel_x),
      .rsp_vel_y         (rsp_vel_y),
      .rsp_vel_z         (rsp_vel_z),
      .rsp_overflow_flag (rsp_overflow_flag),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run: far beyond the slowest legal schedule.
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Response monitor: results cannot be held off, so take every strobe.
   always @(posedge clock) begin
      motion_type got;
      if (!reset && rsp_strobe) begin
         got.pos_x = rsp_pos_x;
         got.pos_y = rsp_pos_y;
         got.pos_z = rsp_pos_z;
         got.vel_x = rsp_vel_x;
         got.vel_y = rsp_vel_y;
         got.vel_z = rsp_vel_z;
         got.ovf   = rsp_overflow_flag;
         board.check_point(got);
      end
   end

   // APB write: setup cycle, access cycle, commit on the edge ending access.
   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         ctfe_pkg::REG_FIELD_ENABLE: board.field_on = val[0];
         ctfe_pkg::REG_DRIFT_SPEED:  board.drift    = wide_type'(signed'(val));
         ctfe_pkg::REG_ANGULAR_FREQ: board.omega    = wide_type'(signed'(val));
         ctfe_pkg::REG_START_VEL_X:  board.v0x      = wide_type'(signed'(val));
         ctfe_pkg::REG_START_VEL_Y:  board.v0y      = wide_type'(signed'(val));
         ctfe_pkg::REG_START_VEL_Z:  board.v0z      = wide_type'(signed'(val));
         ctfe_pkg::REG_START_POS_Y:  board.y0       = wide_type'(signed'(val));
         default: ;
      endcase
   endtask

   // Drop start, drain the pipeline, then let the block settle before
   // touching registers.
   task automatic drain_pipeline();
      start <= 1'b0;
      while (board.due_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic load_setting(logic en, logic [31:0] drift, logic [31:0] omega,
                               logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                               logic [31:0] py);
      drain_pipeline();
      csr_write(ctfe_pkg::REG_FIELD_ENABLE, {31'b0, en});
      csr_write(ctfe_pkg::REG_DRIFT_SPEED, drift);
      csr_write(ctfe_pkg::REG_ANGULAR_FREQ, omega);
      csr_write(ctfe_pkg::REG_START_VEL_X, vx);
      csr_write(ctfe_pkg::REG_START_VEL_Y, vy);
      csr_write(ctfe_pkg::REG_START_VEL_Z, vz);
      csr_write(ctfe_pkg::REG_START_POS_Y, py);
      settings_run++;
   endtask

   // Offer one time point; hold start until the block takes it.
   task automatic send_time(logic [31:0] tp);
      int gap;
      start          <= 1'b1;
      req_time_point <= tp;
      do @(posedge clock); while (busy);
      board.note_time(tp);
      sent++;
      gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
         start          <= 1'b0;
         req_time_point <= $urandom;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_time();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 32'h0004_0000);
         2: return $urandom_range(0, 32'h0100_0000);
         default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      endcase
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
      endcase
   endfunction

   initial begin
      logic [31:0] edge_times[8];
      board          = new();
      reset          = 1'b1;
      start          = 1'b0;
      req_time_point = 32'h0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = 5'h0;
      pwdata         = 32'h0;
      idle_pct       = 0;
      sent           = 0;
      settings_run   = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      edge_times = '{32'h0, 32'h1, 32'h0001_0000, 32'h0000_8000, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'hFFFF_FFFF, 32'h0003_243F};

      // Directed: reset defaults (straight line at rest), then a nominal
      // crossed field, a disabled field, zero frequency with the field on,
      // a tiny frequency that blows up D1/D2, and full-scale extreme values.
      send_time(32'h0001_0000);
      load_setting(1'b1, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000,
                   32'h0003_0000, 32'hFFFF_0000, 32'h0000_4000);
      foreach (edge_times[i]) send_time(edge_times[i]);
      load_setting(1'b0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                   32'h0);
      send_time(32'hFFFF_FFFF);
      send_time(32'h0000_0001);
      send_time(32'h0000_8000);
      load_setting(1'b1, 32'h0001_0000, 32'h0, 32'h0002_0000, 32'hFFFE_0000,
                   32'h0000_0001, 32'h0);
      send_time(32'h0010_0000);
      send_time(32'h0);
      load_setting(1'b1, 32'h8000_0000, 32'h0000_0001, 32'h0, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF);
      send_time(32'h0001_0000);
      send_time(32'hFFFF_FFFF);
      load_setting(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h8000_0000);
      send_time(32'h0000_0100);
      send_time(32'h8000_0000);

      // Random: 8 settings of 100 points. Sender idles 28% then 76% then
      // not at all; each setting change makes the sender wait out every
      // result still due.
      for (int s = 0; s < 8; s++) begin
         idle_pct = (s < 3) ? 28 : (s < 6) ? 76 : 0;
         load_setting((s % 4) != 3, pick_value(), (s == 5) ? 32'h0 : pick_value(),
                      pick_value(), pick_value(), pick_value(), pick_value());
         for (int n = 0; n < 100; n++) send_time(pick_time());
      end
      start <= 1'b0;

      drain_pipeline();
      $display("Covered %0d time points over %0d register settings, %0d results checked.",
               sent, settings_run, board.checked);
      $display("Settings spanned disabled, zero-frequency, saturating and nominal fields.");
      if (board.errors == 0 && board.due_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
